[rtl/reversible_deque_top_macros.svh]
// Assertion macros for the deque. Bodies are empty when SYNTHESIS is defined.
`ifndef REVERSIBLE_DEQUE_TOP_MACROS_SVH
`define REVERSIBLE_DEQUE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RDQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");
// next-cycle implication
`define RDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");
`else
`define RDQ_ASSERT_NOW(lbl, ante, cons)
`define RDQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/rdq_pkg.sv]
`timescale 1ns / 1ps
package rdq_pkg;

  localparam int DEPTH   = 256;
  localparam int AW      = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 9;
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REVERSE    = 2'd3;

  typedef logic [AW-1:0]     addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  // slot memory access for one command
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } mem_t;

  // status part of a result
  typedef struct packed {
    logic               pop_valid;
    logic               was_empty;
    logic               was_full;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

[rtl/rdq_if.sv]
`timescale 1ns / 1ps
interface rdq_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [rdq_pkg::CMD_W-1:0]             cmd;
  logic signed [rdq_pkg::DATA_W-1:0]     value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface rdq_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rdq_pkg::DATA_W-1:0]     popped_value;
  logic                                  pop_valid;
  logic                                  was_empty;
  logic                                  was_full;
  logic [rdq_pkg::COUNT_W-1:0]           count;

  modport source (output valid, popped_value, pop_valid, was_empty, was_full, count,
                  input ready);
  modport sink   (input valid, popped_value, pop_valid, was_empty, was_full, count,
                  output ready);
endinterface

[rtl/rdq_ram.sv]
`timescale 1ns / 1ps
module rdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/rdq_ctrl.sv]
`timescale 1ns / 1ps
module rdq_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         acc,
  input  logic [rdq_pkg::CMD_W-1:0]    cmd,
  input  rdq_pkg::data_t               value,
  output rdq_pkg::mem_t                mem,
  output rdq_pkg::res_t                res,
  output rdq_pkg::cnt_t                cnt
);

  rdq_pkg::addr_t head, head_next;
  rdq_pkg::cnt_t  cnt_next;
  logic           reversed, reversed_next;
  logic           full, empty;
  rdq_pkg::addr_t cnt_lo, last_off;

  assign full     = (cnt == rdq_pkg::cnt_t'(rdq_pkg::DEPTH));
  assign empty    = (cnt == '0);
  assign cnt_lo   = cnt[rdq_pkg::AW-1:0];
  assign last_off = cnt_lo - rdq_pkg::addr_t'(1);

  always_comb begin
    head_next     = head;
    cnt_next      = cnt;
    reversed_next = reversed;
    mem           = '0;
    mem.wdata     = value;
    res           = '0;
    case (cmd)
      rdq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          res.was_full = 1'b1;
        end else begin
          head_next = reversed ? head + rdq_pkg::addr_t'(1) : head - rdq_pkg::addr_t'(1);
          mem.we    = 1'b1;
          mem.waddr = head_next;
          cnt_next  = cnt + rdq_pkg::cnt_t'(1);
        end
      end
      rdq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          res.was_full = 1'b1;
        end else begin
          mem.we    = 1'b1;
          mem.waddr = reversed ? head - cnt_lo : head + cnt_lo;
          cnt_next  = cnt + rdq_pkg::cnt_t'(1);
        end
      end
      rdq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          res.was_empty = 1'b1;
        end else begin
          res.pop_valid = 1'b1;
          mem.re        = 1'b1;
          mem.raddr     = head;
          head_next     = reversed ? head - rdq_pkg::addr_t'(1) : head + rdq_pkg::addr_t'(1);
          cnt_next      = cnt - rdq_pkg::cnt_t'(1);
        end
      end
      default: begin
        // reverse: head moves to the old back element
        if (!empty) begin
          head_next = reversed ? head - last_off : head + last_off;
        end
        reversed_next = !reversed;
      end
    endcase
    res.count = rdq_pkg::COUNT_W'(cnt_next);
    if (!acc) begin
      mem.we = 1'b0;
      mem.re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      cnt      <= '0;
      reversed <= 1'b0;
    end else if (acc) begin
      head     <= head_next;
      cnt      <= cnt_next;
      reversed <= reversed_next;
    end
  end

endmodule

[rtl/reversible_deque_top.sv]
`timescale 1ns / 1ps
// Reversible deque of up to 256 signed 32-bit values held in one slot memory.
// Commands: push front, push back, pop front, reverse. Every accepted command
// gives exactly one result, written to the output register as it is accepted, and a new
// command is taken in every cycle in which that register is empty or being
// drained, so the sustained rate is one command per clock. A pop reads the
// slot memory at the edge it is accepted; the registered read data forms the
// popped value of its result. Reverse only moves the head and flips the
// direction flag. The slot memory is never cleared: no start-up pass.
`include "reversible_deque_top_macros.svh"

module reversible_deque_top (
  input logic      clk,
  input logic      rst,
  rdq_req_if.sink   req,
  rdq_rsp_if.source rsp
);

  logic           acc;
  rdq_pkg::mem_t  mem;
  rdq_pkg::res_t  res, ores;
  rdq_pkg::cnt_t  cnt;
  rdq_pkg::data_t rdata;
  logic           ovalid;

  assign req.ready = !ovalid || rsp.ready;
  assign acc       = req.valid && req.ready;

  rdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .acc   (acc),
    .cmd   (req.cmd),
    .value (rdq_pkg::data_t'(req.value)),
    .mem   (mem),
    .res   (res),
    .cnt   (cnt)
  );

  // each command touches at most one slot and state updates at accept,
  // so a pop right after a push to the same slot sees the written data
  rdq_ram #(
    .WIDTH (rdq_pkg::DATA_W),
    .DEPTH (rdq_pkg::DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (acc) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ores <= res;
    end
  end

  assign rsp.valid        = ovalid;
  assign rsp.popped_value = ores.pop_valid ? rdata : '0;
  assign rsp.pop_valid    = ores.pop_valid;
  assign rsp.was_empty    = ores.was_empty;
  assign rsp.was_full     = ores.was_full;
  assign rsp.count        = ores.count;

  `RDQ_ASSERT_NOW(a_cnt_range, 1'b1, cnt <= rdq_pkg::cnt_t'(rdq_pkg::DEPTH))
  `RDQ_ASSERT_NEXT(a_acc_result, acc, ovalid)
  `RDQ_ASSERT_NEXT(a_pop_ok,
                   acc && req.cmd == rdq_pkg::CMD_POP_FRONT && cnt != '0,
                   ores.pop_valid && cnt == $past(cnt) - rdq_pkg::cnt_t'(1))
  `RDQ_ASSERT_NEXT(a_push_ok,
                   acc && req.cmd == rdq_pkg::CMD_PUSH_BACK &&
                   cnt != rdq_pkg::cnt_t'(rdq_pkg::DEPTH),
                   !ores.was_full && cnt == $past(cnt) + rdq_pkg::cnt_t'(1))

endmodule

[sim/tb_reversible_deque_top.sv]
`timescale 1ns / 1ps
module tb_reversible_deque_top;
  import rdq_pkg::*;

  typedef logic [CMD_W-1:0] cmd_t;

  typedef struct packed {
    data_t              popped_value;
    logic               pop_valid;
    logic               was_empty;
    logic               was_full;
    logic [COUNT_W-1:0] count;
  } dq_res_t;

  // one directed transaction; want is used only when typed is set
  typedef struct packed {
    cmd_t    cmd;
    data_t   value;
    logic    typed;
    dq_res_t want;
  } step_t;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED, BURST_SWING} burst_e;

  localparam int N_DIR    = 25;
  localparam int N_RAND   = 1800;
  localparam int MAX_SHOW = 10;

  logic clk = 1'b0;
  logic rst;

  rdq_req_if req ();
  rdq_rsp_if rsp ();

  reversible_deque_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow deque
  data_t ring_mem [DEPTH];
  addr_t front_slot  = '0;
  cnt_t  held_count  = '0;
  logic  dir_flipped = 1'b0;

  dq_res_t deque_res_q [$];
  dq_res_t chk_want;
  int unsigned bad_cnt = 0;

  step_t dir_tab [N_DIR] = '{
    '{CMD_POP_FRONT,  32'hDEAD_BEEF, 1'b1, '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 9'd0}},
    '{CMD_REVERSE,    32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 9'd1}},
    '{CMD_PUSH_BACK,  32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 9'd2}},
    '{CMD_PUSH_FRONT, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 9'd3}},
    '{CMD_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 9'd4}},
    '{CMD_REVERSE,    32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 9'd4}},
    '{CMD_POP_FRONT,  32'h1234_5678, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 9'd3}},
    '{CMD_PUSH_FRONT, 32'h5555_5555, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 9'd4}},
    '{CMD_PUSH_BACK,  32'hAAAA_AAAA, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 9'd5}},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h5555_5555, 1'b1, 1'b0, 1'b0, 9'd4}},
    '{CMD_POP_FRONT,  32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 9'd3}},
    '{CMD_REVERSE,    32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 9'd3}},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 9'd2}},
    '{CMD_REVERSE,    32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 9'd2}},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 9'd1}},
    '{CMD_REVERSE,    32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 9'd1}},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 9'd0}},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 9'd0}},
    '{CMD_PUSH_BACK,  32'h1234_5678, 1'b0, '0},
    '{CMD_REVERSE,    32'h0000_0000, 1'b0, '0},
    '{CMD_PUSH_FRONT, 32'hEDCB_A987, 1'b0, '0},
    '{CMD_PUSH_BACK,  32'h0F0F_0F0F, 1'b0, '0},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, '0},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, '0}
  };

  // physical slot of the element off places from the front
  function automatic addr_t slot_of(input cnt_t off);
    addr_t o;
    o = addr_t'(off);
    return dir_flipped ? addr_t'(front_slot - o) : addr_t'(front_slot + o);
  endfunction

  function automatic dq_res_t deque_apply(input cmd_t c, input data_t v);
    dq_res_t r;
    r = '0;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (held_count == cnt_t'(DEPTH)) begin
          r.was_full = 1'b1;
        end else begin
          if (c == CMD_PUSH_FRONT) begin
            // head steps one slot against the list order
            front_slot = dir_flipped ? addr_t'(front_slot + 1'b1)
                                     : addr_t'(front_slot - 1'b1);
            ring_mem[front_slot] = v;
          end else begin
            ring_mem[slot_of(held_count)] = v;
          end
          held_count = held_count + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (held_count == '0) begin
          r.was_empty = 1'b1;
        end else begin
          r.popped_value = ring_mem[front_slot];
          r.pop_valid    = 1'b1;
          front_slot     = slot_of(cnt_t'(1));
          held_count     = held_count - 1'b1;
        end
      end
      default: begin
        if (held_count != '0) front_slot = slot_of(held_count - 1'b1);
        dir_flipped = !dir_flipped;
      end
    endcase
    r.count = held_count;
    return r;
  endfunction

  function automatic data_t pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // mostly back to back, some short gaps, rare long ones
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic send_cmd(input cmd_t c, input data_t v, input int gap,
                          input logic typed, input dq_res_t want);
    dq_res_t pred;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd   <= c;
    req.value <= v;
    do @(posedge clk); while (!req.ready);
    pred = deque_apply(c, v);
    deque_res_q.push_back(typed ? want : pred);
  endtask

  // sink stalls: held for a random number of cycles, occasional long open or closed stretch
  int unsigned sink_hold = 0;
  int unsigned sink_pick;

  initial rsp.ready = 1'b0;

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      sink_pick = $urandom_range(0, 99);
      if (sink_pick < 45) begin
        rsp.ready <= 1'b1;
        sink_hold <= $urandom_range(0, 3);
      end else if (sink_pick < 52) begin
        rsp.ready <= 1'b1;
        sink_hold <= $urandom_range(30, 120);
      end else if (sink_pick < 90) begin
        rsp.ready <= 1'b0;
        sink_hold <= $urandom_range(0, 2);
      end else if (sink_pick < 97) begin
        rsp.ready <= 1'b0;
        sink_hold <= $urandom_range(3, 8);
      end else begin
        rsp.ready <= 1'b0;
        sink_hold <= $urandom_range(20, 60);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (deque_res_q.size() == 0) begin
        if (bad_cnt < MAX_SHOW)
          $display("%0t: result with none pending: val=%h pv=%b em=%b fu=%b cnt=%0d",
                   $time, rsp.popped_value, rsp.pop_valid, rsp.was_empty,
                   rsp.was_full, rsp.count);
        bad_cnt <= bad_cnt + 1;
      end else begin
        chk_want = deque_res_q.pop_front();
        if (rsp.popped_value !== chk_want.popped_value ||
            rsp.pop_valid    !== chk_want.pop_valid    ||
            rsp.was_empty    !== chk_want.was_empty    ||
            rsp.was_full     !== chk_want.was_full     ||
            rsp.count        !== chk_want.count) begin
          if (bad_cnt < MAX_SHOW)
            $display({"%0t: mismatch exp val=%h pv=%b em=%b fu=%b cnt=%0d",
                      " | got val=%h pv=%b em=%b fu=%b cnt=%0d"}, $time,
                     chk_want.popped_value, chk_want.pop_valid, chk_want.was_empty,
                     chk_want.was_full, chk_want.count, rsp.popped_value,
                     rsp.pop_valid, rsp.was_empty, rsp.was_full, rsp.count);
          bad_cnt <= bad_cnt + 1;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[reversible_deque_top] ERROR");
    $finish;
  end

  initial begin
    int     sent;
    int     burst_no;
    int     len;
    int     p;
    int     w;
    logic   quiet;
    burst_e mode;
    cmd_t   c;

    rst       = 1'b1;
    req.valid = 1'b0;
    req.cmd   = CMD_PUSH_FRONT;
    req.value = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++)
      send_cmd(dir_tab[i].cmd, dir_tab[i].value, pick_gap(), dir_tab[i].typed,
               dir_tab[i].want);

    // first burst fills past full, second drains past empty, then random mix
    sent     = 0;
    burst_no = 0;
    while (sent < N_RAND) begin
      if (burst_no == 0) mode = BURST_FILL;
      else if (burst_no == 1) mode = BURST_DRAIN;
      else mode = burst_e'($urandom_range(0, 3));
      len   = (burst_no < 2) ? 400 : $urandom_range(40, 200);
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len && sent < N_RAND; k++) begin
        p = $urandom_range(0, 99);
        case (mode)
          BURST_FILL:  c = (p < 92) ? cmd_t'($urandom_range(0, 1)) :
                           (p < 97) ? CMD_POP_FRONT : CMD_REVERSE;
          BURST_DRAIN: c = (p < 85) ? CMD_POP_FRONT :
                           (p < 90) ? CMD_REVERSE : cmd_t'($urandom_range(0, 1));
          BURST_SWING: c = (p < 50) ? cmd_t'($urandom_range(0, 1)) :
                           (p < 90) ? CMD_POP_FRONT : CMD_REVERSE;
          default:     c = cmd_t'($urandom_range(0, 3));
        endcase
        send_cmd(c, pick_value(), quiet ? 0 : pick_gap(), 1'b0, '0);
        sent++;
      end
      burst_no++;
    end
    req.valid <= 1'b0;

    for (w = 0; w < 5000 && deque_res_q.size() != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);

    if (bad_cnt == 0 && deque_res_q.size() == 0) begin
      $display("[reversible_deque_top] OK");
    end else begin
      $display("[reversible_deque_top] ERROR");
    end
    $finish;
  end

endmodule
